// ===== hw/rtl/gbha_pkg.sv =====
package gbha_pkg;

  localparam int MAX_GROUPS_DEF = 256;

  // Request commands
  localparam logic [1:0] CMD_ACCUM = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Aggregate functions; every other code sums
  localparam logic [2:0] AGG_COUNT = 3'd0;
  localparam logic [2:0] AGG_SUM   = 3'd1;
  localparam logic [2:0] AGG_MIN   = 3'd2;
  localparam logic [2:0] AGG_MAX   = 3'd3;
  localparam logic [2:0] AGG_AVG   = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_AGG_FUNC  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STAR_MODE = 8'd1;

  typedef struct packed {
    logic [1:0]         command;
    logic               key_null;
    logic signed [63:0] key_value;
    logic               value_null;
    logic signed [63:0] value_in;
    logic [7:0]         group_index;
  } in_t;

  typedef struct packed {
    logic [7:0]         group_id;
    logic               new_group;
    logic               table_full;
    logic [8:0]         group_total;
    logic signed [63:0] out_key;
    logic               out_key_null;
    logic [31:0]        out_count;
    logic               agg_seen;
    logic signed [63:0] agg_value;
    logic               index_valid;
  } out_t;

  // Request in flight along the cell chain, with its partial result
  typedef struct packed {
    in_t  req;
    out_t rsp;
    logic found;
  } pkt_t;

  // Settings broadcast to every cell
  typedef struct packed {
    logic [2:0] agg_func;
    logic       star_mode;
  } cfg_t;

endpackage

// ===== hw/rtl/gbha_cell.sv =====
module gbha_cell #(
  parameter int CELL_IDX = 0,
  parameter int IDX_W    = 8,
  parameter int CNT_W    = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gbha_pkg::cfg_t      cfg_i,
  input  logic [CNT_W-1:0]    used_i,
  input  logic                vld_i,
  input  gbha_pkg::pkt_t      pkt_i,
  output logic                vld_o,
  output gbha_pkg::pkt_t      pkt_o
);

  localparam int XW = IDX_W + 8;

  // One group entry; undefined until the group is created here
  logic signed [63:0] key_r,  key_nxt;
  logic               kn_r,   kn_nxt;
  logic [31:0]        cnt_r,  cnt_nxt;
  logic               seen_r, seen_nxt;
  logic signed [63:0] acc_r,  acc_nxt;
  logic               wr_en;

  logic           vld_r;
  gbha_pkg::pkt_t pkt_r, pkt_nxt;

  logic               in_use, hit, create, accum;
  logic [31:0]        base_cnt, sat_cnt;
  logic               base_seen;
  logic signed [63:0] base_acc, v;

  always_comb begin
    in_use  = CNT_W'(CELL_IDX) < used_i;
    accum   = vld_i && (pkt_i.req.command == gbha_pkg::CMD_ACCUM) && !pkt_i.found;
    hit     = accum && in_use &&
              (pkt_i.req.key_null ? kn_r
                                  : (!kn_r && (key_r == pkt_i.req.key_value)));
    create  = accum && !hit && (used_i == CNT_W'(CELL_IDX));
    v       = pkt_i.req.value_in;

    base_cnt  = create ? 32'd0 : cnt_r;
    base_seen = create ? 1'b0  : seen_r;
    base_acc  = create ? 64'sd0 : acc_r;
    sat_cnt   = (base_cnt == 32'hFFFF_FFFF) ? base_cnt : base_cnt + 32'd1;

    key_nxt  = create ? (pkt_i.req.key_null ? 64'sd0 : pkt_i.req.key_value) : key_r;
    kn_nxt   = create ? pkt_i.req.key_null : kn_r;
    cnt_nxt  = base_cnt;
    seen_nxt = base_seen;
    acc_nxt  = base_acc;
    if (cfg_i.star_mode) begin
      cnt_nxt  = sat_cnt;
      seen_nxt = 1'b1;
    end else if (!pkt_i.req.value_null) begin
      cnt_nxt  = sat_cnt;
      seen_nxt = 1'b1;
      if (!base_seen) begin
        acc_nxt = v;
      end else begin
        case (cfg_i.agg_func)
          gbha_pkg::AGG_MIN: acc_nxt = (v < base_acc) ? v : base_acc;
          gbha_pkg::AGG_MAX: acc_nxt = (base_acc < v) ? v : base_acc;
          default:           acc_nxt = base_acc + v;
        endcase
      end
    end
    wr_en = hit || create;

    pkt_nxt = pkt_i;
    if (wr_en) begin
      pkt_nxt.found         = 1'b1;
      pkt_nxt.rsp.group_id  = 8'(CELL_IDX);
      pkt_nxt.rsp.new_group = create;
    end
    if (vld_i && (pkt_i.req.command == gbha_pkg::CMD_READ) && in_use &&
        (XW'(pkt_i.req.group_index) == XW'(CELL_IDX))) begin
      pkt_nxt.rsp.out_key      = key_r;
      pkt_nxt.rsp.out_key_null = kn_r;
      pkt_nxt.rsp.out_count    = cnt_r;
      pkt_nxt.rsp.agg_seen     = seen_r;
      pkt_nxt.rsp.agg_value    = acc_r;
      pkt_nxt.rsp.index_valid  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r  <= key_nxt;
      kn_r   <= kn_nxt;
      cnt_r  <= cnt_nxt;
      seen_r <= seen_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
    pkt_r <= pkt_nxt;
  end

  assign vld_o = vld_r;
  assign pkt_o = pkt_r;

endmodule

// ===== hw/rtl/group_by_hash_aggregate_top.sv =====
// Group-by aggregation engine: one integer aggregate over a nullable 64-bit key.
//
// Request channel: drive in_req and raise start; the request is taken at the
// clock edge where start is high and busy is low. Commands accumulate a row,
// read one group, or clear the table.
// Result channel: every request yields one result, shown on out_rsp for one
// cycle with out_valid high. There is no back-pressure; the receiver must
// take it in that cycle.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// the aggregate function, index 1 the count-star flag. Write only while idle.
// Pipeline: the request walks a chain of MAX_GROUPS cells, one cell per cycle,
// each cell holding one group; the result strobe rises once the request has
// left the last cell and its result has been registered. busy drops
// together with the strobe, so a new request can be taken only once the
// previous result is shown.
// Reset: group count and settings go to zero; stored entries stay undefined
// and are never read until a row creates them. Clear zeroes only the group count.
module group_by_hash_aggregate_top #(
  parameter int MAX_GROUPS = gbha_pkg::MAX_GROUPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  gbha_pkg::in_t                     in_req,
  output logic                              out_valid,
  output gbha_pkg::out_t                    out_rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gbha_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gbha_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(MAX_GROUPS);
  localparam int CNT_W = $clog2(MAX_GROUPS + 1);

  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  gbha_pkg::cfg_t       cfg_r;
  logic                 out_valid_r;
  gbha_pkg::out_t       out_r, out_nxt;
  logic [CNT_W+8:0]     total_ext;
  logic                 accept;

  logic                 chain_vld [0:MAX_GROUPS];
  gbha_pkg::pkt_t       chain_pkt [0:MAX_GROUPS];
  gbha_pkg::pkt_t       tail;

  assign accept    = start && !busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Launch the request into the head of the chain with an empty result
  assign chain_vld[0] = accept;
  assign chain_pkt[0] = {in_req, gbha_pkg::out_t'('0), 1'b0};

  for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_cell
    gbha_cell #(
      .CELL_IDX (i),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cfg_i  (cfg_r),
      .used_i (used_r),
      .vld_i  (chain_vld[i]),
      .pkt_i  (chain_pkt[i]),
      .vld_o  (chain_vld[i+1]),
      .pkt_o  (chain_pkt[i+1])
    );
  end

  // Finish the request at the tail: flag drops, set id and total, update group count
  always_comb begin
    tail     = chain_pkt[MAX_GROUPS];
    used_nxt = used_r;
    case (tail.req.command)
      gbha_pkg::CMD_ACCUM: begin
        if (tail.rsp.new_group) begin
          used_nxt = used_r + CNT_W'(1);
        end
      end
      gbha_pkg::CMD_READ: begin
        used_nxt = used_r;
      end
      gbha_pkg::CMD_CLEAR: begin
        used_nxt = '0;
      end
      default: begin
        used_nxt = used_r;
      end
    endcase
    total_ext = (CNT_W + 9)'(used_nxt);
    out_nxt   = tail.rsp;
    if (tail.req.command == gbha_pkg::CMD_READ) begin
      out_nxt.group_id = tail.req.group_index;
    end
    if ((tail.req.command == gbha_pkg::CMD_ACCUM) && !tail.found) begin
      out_nxt.table_full = 1'b1;
    end
    out_nxt.group_total = total_ext[8:0];

    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (chain_vld[MAX_GROUPS]) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      cfg_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= chain_vld[MAX_GROUPS];
      if (chain_vld[MAX_GROUPS]) begin
        used_r <= used_nxt;
      end
      if (cfg_valid && (cfg_index == gbha_pkg::CFG_AGG_FUNC)) begin
        cfg_r.agg_func <= cfg_data[2:0];
      end
      if (cfg_valid && (cfg_index == gbha_pkg::CFG_STAR_MODE)) begin
        cfg_r.star_mode <= cfg_data[0];
      end
    end
    if (chain_vld[MAX_GROUPS]) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // Release busy only together with the result strobe
  a_busy_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r)
    else $error("busy released without a result");

  // One result per request; the chain never yields two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("back-to-back result strobes");

  // Hold the group count within the table size
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(MAX_GROUPS))
    else $error("group count beyond table size");

  // Drop a row only when the table is full
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.table_full) |-> (used_r == CNT_W'(MAX_GROUPS)))
    else $error("row dropped with free entries left");

endmodule
